### design/chip8_processor_core_defines.svh
// ---------------------------------------------------------------------------
// CHIP-8 core assertion macros
// Shared property wrappers for the checks at the end of the core.
// ---------------------------------------------------------------------------
`ifndef CHIP8_PROCESSOR_CORE_DEFINES_SVH
`define CHIP8_PROCESSOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define C8_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define C8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/chip8_pkg.sv
// ---------------------------------------------------------------------------
// CHIP-8 core package
// Request and result types, opcode codes, font table and sizing constants.
// ---------------------------------------------------------------------------
package chip8_pkg;

  localparam int unsigned MEM_BYTES       = 4096;
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned FONT_BYTES      = 80;
  localparam logic [11:0] PC_RESET        = 12'h200;

  // Request functions
  localparam logic [2:0] FUNC_MEM_WR  = 3'd0;
  localparam logic [2:0] FUNC_MEM_RD  = 3'd1;
  localparam logic [2:0] FUNC_SET_KEY = 3'd2;
  localparam logic [2:0] FUNC_TICK    = 3'd3;
  localparam logic [2:0] FUNC_EXEC    = 3'd4;
  localparam logic [2:0] FUNC_ROW_RD  = 3'd5;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  // Full opcodes
  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  // Opcode high nibble
  localparam logic [3:0] OPH_SYS    = 4'h0;
  localparam logic [3:0] OPH_JP     = 4'h1;
  localparam logic [3:0] OPH_CALL   = 4'h2;
  localparam logic [3:0] OPH_SE_NN  = 4'h3;
  localparam logic [3:0] OPH_SNE_NN = 4'h4;
  localparam logic [3:0] OPH_SE_XY  = 4'h5;
  localparam logic [3:0] OPH_LD_NN  = 4'h6;
  localparam logic [3:0] OPH_ADD_NN = 4'h7;
  localparam logic [3:0] OPH_ALU    = 4'h8;
  localparam logic [3:0] OPH_SNE_XY = 4'h9;
  localparam logic [3:0] OPH_LD_I   = 4'hA;
  localparam logic [3:0] OPH_JP_V0  = 4'hB;
  localparam logic [3:0] OPH_RND    = 4'hC;
  localparam logic [3:0] OPH_DRW    = 4'hD;
  localparam logic [3:0] OPH_KEY    = 4'hE;
  localparam logic [3:0] OPH_MISC   = 4'hF;

  // 8XYN register operations
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // Low byte selectors for EXNN and FXNN
  localparam logic [7:0] NN_SKP      = 8'h9E;
  localparam logic [7:0] NN_SKNP     = 8'hA1;
  localparam logic [7:0] NN_GET_DT   = 8'h07;
  localparam logic [7:0] NN_WAIT_KEY = 8'h0A;
  localparam logic [7:0] NN_SET_DT   = 8'h15;
  localparam logic [7:0] NN_SET_ST   = 8'h18;
  localparam logic [7:0] NN_ADD_I    = 8'h1E;
  localparam logic [7:0] NN_FONT     = 8'h29;
  localparam logic [7:0] NN_BCD      = 8'h33;
  localparam logic [7:0] NN_STORE    = 8'h55;
  localparam logic [7:0] NN_LOAD     = 8'h65;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [3:0]  key_index;
    logic        key_down;
    logic [7:0]  rand_byte;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pc_now;
    logic [15:0] opcode_done;
    logic [7:0]  read_byte;
    logic [63:0] row_pixels;
    logic        display_changed;
    logic        waiting_key;
    logic        sound_on;
    logic [1:0]  status;
  } out_item_t;

endpackage

### design/chip8_processor_core.sv
// ---------------------------------------------------------------------------
// CHIP-8 processor core
// Memory, registers, stack, display, timers and keypad behind one request
// channel; one 17-bit adder is shared by the sequencer's address and arithmetic steps.
// ---------------------------------------------------------------------------
// After reset the core loads the 80-byte hex font into memory and takes no
// request meanwhile. It then works on one request at a time; DXYN and
// FX55/FX65 repeat their states per sprite row or register and FX33 per
// subtraction. A finished result sits in an output register, so a stalled
// consumer only holds the core once a second result is ready.
`include "chip8_processor_core_defines.svh"

module chip8_processor_core #(
  parameter int unsigned STACK_DEPTH = chip8_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  chip8_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output chip8_pkg::out_item_t out_data
);

  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

  typedef enum logic [27:0] {
    ST_FILL   = 28'd1 << 0,
    ST_IDLE   = 28'd1 << 1,
    ST_SIMPLE = 28'd1 << 2,
    ST_MEMR   = 28'd1 << 3,
    ST_MEMR2  = 28'd1 << 4,
    ST_ROW    = 28'd1 << 5,
    ST_ROW2   = 28'd1 << 6,
    ST_FETCH0 = 28'd1 << 7,
    ST_FETCH1 = 28'd1 << 8,
    ST_FETCH2 = 28'd1 << 9,
    ST_RDX    = 28'd1 << 10,
    ST_RDY    = 28'd1 << 11,
    ST_GETY   = 28'd1 << 12,
    ST_PCINC  = 28'd1 << 13,
    ST_EXE    = 28'd1 << 14,
    ST_FLAGW  = 28'd1 << 15,
    ST_DR0    = 28'd1 << 16,
    ST_DR1    = 28'd1 << 17,
    ST_BH     = 28'd1 << 18,
    ST_BT     = 28'd1 << 19,
    ST_BW0    = 28'd1 << 20,
    ST_BW1    = 28'd1 << 21,
    ST_BW2    = 28'd1 << 22,
    ST_ST0    = 28'd1 << 23,
    ST_ST1    = 28'd1 << 24,
    ST_LD0    = 28'd1 << 25,
    ST_LD1    = 28'd1 << 26,
    ST_DONE   = 28'd1 << 27
  } state_t;

  // Control registers
  state_t               state_r, state_nxt;
  logic [6:0]           fill_cnt_r, fill_cnt_nxt;
  logic [11:0]          pc_r, pc_nxt;
  logic [15:0]          i_r, i_nxt;
  logic [SP_W-1:0]      sp_r, sp_nxt;
  logic [7:0]           delay_r, delay_nxt;
  logic [7:0]           sound_r, sound_nxt;
  logic [15:0]          keys_r, keys_nxt;
  logic [15:0]          rf_vld_r, rf_vld_nxt;
  logic [31:0]          fr_vld_r, fr_vld_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Payload registers
  chip8_pkg::in_item_t  req_r, req_nxt;
  chip8_pkg::out_item_t res_r, res_nxt;
  chip8_pkg::out_item_t out_r, out_nxt;
  logic [15:0]          op_r, op_nxt;
  logic [7:0]           vx_r, vx_nxt;
  logic [7:0]           vy_r, vy_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic [7:0]           aux_r, aux_nxt;
  logic [1:0]           hund_r, hund_nxt;
  logic [3:0]           tens_r, tens_nxt;
  logic                 vf_r, vf_nxt;

  // Memories
  logic [7:0]           main_mem_r [chip8_pkg::MEM_BYTES];
  logic [7:0]           mem_q_r;
  logic                 mem_we;
  logic [11:0]          mem_waddr, mem_raddr;
  logic [7:0]           mem_wdata;

  logic [7:0]           rf_mem_r [16];
  logic [7:0]           rf_q_r;
  logic                 rf_we;
  logic [3:0]           rf_waddr, rf_raddr;
  logic [7:0]           rf_wdata;

  logic [63:0]          frame_mem_r [32];
  logic [63:0]          fr_q_r;
  logic                 fr_we;
  logic [4:0]           fr_raddr;
  logic [63:0]          fr_wdata;

  logic [11:0]          stack_r [STACK_DEPTH];
  logic                 stk_we;

  // Shared adder
  logic [15:0]          alu_a, alu_b;
  logic                 alu_cin;
  logic [16:0]          alu_sum;

  // Decode helpers
  logic [3:0]           op_x, op_n;
  logic [7:0]           op_nn;
  logic [11:0]          op_nnn;
  logic [SP_W-1:0]      sp_dec;
  logic [5:0]           draw_row;
  logic [63:0]          sprite_bits;
  logic [3:0]           key_hit;

  assign op_x       = op_r[11:8];
  assign op_n       = op_r[3:0];
  assign op_nn      = op_r[7:0];
  assign op_nnn     = op_r[11:0];
  assign sp_dec     = sp_r - SP_W'(1);
  assign draw_row   = {1'b0, vy_r[4:0]} + {2'b00, cnt_r};
  assign sprite_bits = {mem_q_r, 56'h0} >> vx_r[5:0];
  assign alu_sum    = {1'b0, alu_a} + {1'b0, alu_b} + {16'h0, alu_cin};

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Lowest pressed key
  always_comb begin
    key_hit = 4'h0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) key_hit = 4'(k);
    end
  end

  // Select adder operands for the current step
  always_comb begin
    alu_a   = 16'h0;
    alu_b   = 16'h0;
    alu_cin = 1'b0;
    unique case (state_r)
      ST_FETCH1: begin
        alu_a = {4'h0, pc_r};
        alu_b = 16'd1;
      end
      ST_PCINC: begin
        alu_a = {4'h0, pc_r};
        alu_b = 16'd2;
      end
      ST_EXE: begin
        unique case (op_r[15:12])
          chip8_pkg::OPH_SE_NN, chip8_pkg::OPH_SNE_NN, chip8_pkg::OPH_SE_XY,
          chip8_pkg::OPH_SNE_XY, chip8_pkg::OPH_KEY: begin
            alu_a = {4'h0, pc_r};
            alu_b = 16'd2;
          end
          chip8_pkg::OPH_ADD_NN: begin
            alu_a = {8'h0, vx_r};
            alu_b = {8'h0, op_nn};
          end
          chip8_pkg::OPH_ALU: begin
            unique case (op_n)
              chip8_pkg::ALU_ADD: begin
                alu_a = {8'h0, vx_r};
                alu_b = {8'h0, vy_r};
              end
              chip8_pkg::ALU_SUB: begin
                alu_a   = {8'h0, vx_r};
                alu_b   = {8'h0, ~vy_r};
                alu_cin = 1'b1;
              end
              chip8_pkg::ALU_SUBN: begin
                alu_a   = {8'h0, vy_r};
                alu_b   = {8'h0, ~vx_r};
                alu_cin = 1'b1;
              end
              default: begin
              end
            endcase
          end
          chip8_pkg::OPH_JP_V0: begin
            alu_a = {4'h0, op_nnn};
            alu_b = {8'h0, vx_r};
          end
          chip8_pkg::OPH_MISC: begin
            unique case (op_nn)
              chip8_pkg::NN_ADD_I: begin
                alu_a = i_r;
                alu_b = {8'h0, vx_r};
              end
              chip8_pkg::NN_WAIT_KEY: begin
                alu_a = {4'h0, pc_r};
                alu_b = 16'hFFFE;
              end
              chip8_pkg::NN_FONT: begin
                alu_a = {6'h0, vx_r, 2'b00};
                alu_b = {8'h0, vx_r};
              end
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase
      end
      ST_DR0, ST_DR1, ST_ST1, ST_LD0: begin
        alu_a = i_r;
        alu_b = {12'h0, cnt_r};
      end
      ST_BH: begin
        alu_a   = {8'h0, aux_r};
        alu_b   = {8'h0, ~8'd100};
        alu_cin = 1'b1;
      end
      ST_BT: begin
        alu_a   = {8'h0, aux_r};
        alu_b   = {8'h0, ~8'd10};
        alu_cin = 1'b1;
      end
      ST_BW0: alu_a = i_r;
      ST_BW1: begin
        alu_a = i_r;
        alu_b = 16'd1;
      end
      ST_BW2: begin
        alu_a = i_r;
        alu_b = 16'd2;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_cnt_nxt  = fill_cnt_r;
    pc_nxt        = pc_r;
    i_nxt         = i_r;
    sp_nxt        = sp_r;
    delay_nxt     = delay_r;
    sound_nxt     = sound_r;
    keys_nxt      = keys_r;
    rf_vld_nxt    = rf_vld_r;
    fr_vld_nxt    = fr_vld_r;
    out_valid_nxt = out_valid_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    op_nxt        = op_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    cnt_nxt       = cnt_r;
    aux_nxt       = aux_r;
    hund_nxt      = hund_r;
    tens_nxt      = tens_r;
    vf_nxt        = vf_r;
    mem_we        = 1'b0;
    mem_waddr     = alu_sum[11:0];
    mem_wdata     = 8'h0;
    mem_raddr     = alu_sum[11:0];
    rf_we         = 1'b0;
    rf_waddr      = op_x;
    rf_wdata      = 8'h0;
    rf_raddr      = 4'h0;
    fr_we         = 1'b0;
    fr_raddr      = draw_row[4:0];
    fr_wdata      = fr_q_r ^ sprite_bits;
    stk_we        = 1'b0;

    // Drop a taken result
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_FILL: begin
        mem_we       = 1'b1;
        mem_waddr    = {5'h0, fill_cnt_r};
        mem_wdata    = chip8_pkg::FONT[fill_cnt_r];
        fill_cnt_nxt = fill_cnt_r + 7'd1;
        if (fill_cnt_r == 7'(chip8_pkg::FONT_BYTES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          priority if (in_data.func == chip8_pkg::FUNC_MEM_RD) state_nxt = ST_MEMR;
          else if (in_data.func == chip8_pkg::FUNC_ROW_RD) state_nxt = ST_ROW;
          else if (in_data.func == chip8_pkg::FUNC_EXEC) state_nxt = ST_FETCH0;
          else state_nxt = ST_SIMPLE;
        end
      end
      ST_SIMPLE: begin
        priority if (req_r.func == chip8_pkg::FUNC_MEM_WR) begin
          mem_we    = 1'b1;
          mem_waddr = req_r.addr;
          mem_wdata = req_r.data;
        end else if (req_r.func == chip8_pkg::FUNC_SET_KEY) begin
          keys_nxt[req_r.key_index] = req_r.key_down;
        end else if (req_r.func == chip8_pkg::FUNC_TICK) begin
          if (delay_r != 8'h0) delay_nxt = delay_r - 8'd1;
          if (sound_r != 8'h0) sound_nxt = sound_r - 8'd1;
        end
        state_nxt = ST_DONE;
      end
      ST_MEMR: begin
        mem_raddr = req_r.addr;
        state_nxt = ST_MEMR2;
      end
      ST_MEMR2: begin
        res_nxt.read_byte = mem_q_r;
        state_nxt         = ST_DONE;
      end
      ST_ROW: begin
        fr_raddr  = req_r.addr[4:0];
        state_nxt = ST_ROW2;
      end
      ST_ROW2: begin
        if (req_r.addr[11:5] == 7'h0) res_nxt.row_pixels = fr_q_r;
        state_nxt = ST_DONE;
      end
      // Fetch the instruction word, high byte first
      ST_FETCH0: begin
        mem_raddr = pc_r;
        state_nxt = ST_FETCH1;
      end
      ST_FETCH1: begin
        op_nxt[15:8] = mem_q_r;
        state_nxt    = ST_FETCH2;
      end
      ST_FETCH2: begin
        op_nxt[7:0] = mem_q_r;
        state_nxt   = ST_RDX;
      end
      ST_RDX: begin
        rf_raddr  = op_x;
        state_nxt = ST_RDY;
      end
      ST_RDY: begin
        vx_nxt    = rf_q_r;
        rf_raddr  = op_r[7:4];
        state_nxt = ST_GETY;
      end
      ST_GETY: begin
        vy_nxt    = rf_q_r;
        state_nxt = ST_PCINC;
      end
      ST_PCINC: begin
        pc_nxt              = alu_sum[11:0];
        res_nxt.opcode_done = op_r;
        state_nxt           = ST_EXE;
      end
      ST_EXE: begin
        state_nxt = ST_DONE;
        unique case (op_r[15:12])
          chip8_pkg::OPH_SYS: begin
            if (op_r == chip8_pkg::OP_CLS) begin
              fr_vld_nxt              = '0;
              res_nxt.display_changed = 1'b1;
            end else if (op_r == chip8_pkg::OP_RET) begin
              if (sp_r == '0) begin
                res_nxt.status = chip8_pkg::STAT_UNDERFLOW;
              end else begin
                sp_nxt = sp_dec;
                pc_nxt = stack_r[sp_dec[IDX_W-1:0]];
              end
            end
          end
          chip8_pkg::OPH_JP: pc_nxt = op_nnn;
          chip8_pkg::OPH_CALL: begin
            if (sp_r >= SP_W'(STACK_DEPTH)) begin
              res_nxt.status = chip8_pkg::STAT_OVERFLOW;
            end else begin
              stk_we = 1'b1;
              sp_nxt = sp_r + SP_W'(1);
              pc_nxt = op_nnn;
            end
          end
          chip8_pkg::OPH_SE_NN:  if (vx_r == op_nn) pc_nxt = alu_sum[11:0];
          chip8_pkg::OPH_SNE_NN: if (vx_r != op_nn) pc_nxt = alu_sum[11:0];
          chip8_pkg::OPH_SE_XY:  if (vx_r == vy_r) pc_nxt = alu_sum[11:0];
          chip8_pkg::OPH_SNE_XY: if (vx_r != vy_r) pc_nxt = alu_sum[11:0];
          chip8_pkg::OPH_LD_NN: begin
            rf_we    = 1'b1;
            rf_wdata = op_nn;
          end
          chip8_pkg::OPH_ADD_NN: begin
            rf_we    = 1'b1;
            rf_wdata = alu_sum[7:0];
          end
          chip8_pkg::OPH_ALU: begin
            rf_we = 1'b1;
            unique case (op_n)
              chip8_pkg::ALU_MOV: rf_wdata = vy_r;
              chip8_pkg::ALU_OR:  rf_wdata = vx_r | vy_r;
              chip8_pkg::ALU_AND: rf_wdata = vx_r & vy_r;
              chip8_pkg::ALU_XOR: rf_wdata = vx_r ^ vy_r;
              chip8_pkg::ALU_ADD, chip8_pkg::ALU_SUB, chip8_pkg::ALU_SUBN: begin
                rf_wdata  = alu_sum[7:0];
                vf_nxt    = alu_sum[8];
                state_nxt = ST_FLAGW;
              end
              chip8_pkg::ALU_SHR: begin
                rf_wdata  = {1'b0, vx_r[7:1]};
                vf_nxt    = vx_r[0];
                state_nxt = ST_FLAGW;
              end
              chip8_pkg::ALU_SHL: begin
                rf_wdata  = {vx_r[6:0], 1'b0};
                vf_nxt    = vx_r[7];
                state_nxt = ST_FLAGW;
              end
              default: rf_we = 1'b0;
            endcase
          end
          chip8_pkg::OPH_LD_I:  i_nxt = {4'h0, op_nnn};
          chip8_pkg::OPH_JP_V0: pc_nxt = alu_sum[11:0];
          chip8_pkg::OPH_RND: begin
            rf_we    = 1'b1;
            rf_wdata = req_r.rand_byte & op_nn;
          end
          chip8_pkg::OPH_DRW: begin
            vf_nxt    = 1'b0;
            cnt_nxt   = 4'h0;
            state_nxt = ST_DR0;
          end
          chip8_pkg::OPH_KEY: begin
            if (op_nn == chip8_pkg::NN_SKP && keys_r[vx_r[3:0]])
              pc_nxt = alu_sum[11:0];
            else if (op_nn == chip8_pkg::NN_SKNP && !keys_r[vx_r[3:0]])
              pc_nxt = alu_sum[11:0];
          end
          chip8_pkg::OPH_MISC: begin
            unique case (op_nn)
              chip8_pkg::NN_GET_DT: begin
                rf_we    = 1'b1;
                rf_wdata = delay_r;
              end
              chip8_pkg::NN_SET_DT: delay_nxt = vx_r;
              chip8_pkg::NN_SET_ST: sound_nxt = vx_r;
              chip8_pkg::NN_ADD_I:  i_nxt = alu_sum[15:0];
              chip8_pkg::NN_FONT:   i_nxt = alu_sum[15:0];
              chip8_pkg::NN_WAIT_KEY: begin
                if (keys_r != 16'h0) begin
                  rf_we    = 1'b1;
                  rf_wdata = {4'h0, key_hit};
                end else begin
                  pc_nxt              = alu_sum[11:0];
                  res_nxt.waiting_key = 1'b1;
                end
              end
              chip8_pkg::NN_BCD: begin
                aux_nxt   = vx_r;
                hund_nxt  = 2'd0;
                tens_nxt  = 4'd0;
                state_nxt = ST_BH;
              end
              chip8_pkg::NN_STORE: begin
                cnt_nxt   = 4'h0;
                state_nxt = ST_ST0;
              end
              chip8_pkg::NN_LOAD: begin
                cnt_nxt   = 4'h0;
                state_nxt = ST_LD0;
              end
              default: begin
              end
            endcase
          end
        endcase
      end
      // Write the flag after the result so VF wins
      ST_FLAGW: begin
        rf_we     = 1'b1;
        rf_waddr  = 4'hF;
        rf_wdata  = {7'h0, vf_r};
        state_nxt = ST_DONE;
      end
      // Sprite rows: read byte and frame row, then XOR back
      ST_DR0: begin
        if (cnt_r == op_n || draw_row[5]) begin
          res_nxt.display_changed = 1'b1;
          state_nxt               = ST_FLAGW;
        end else begin
          state_nxt = ST_DR1;
        end
      end
      ST_DR1: begin
        fr_we = 1'b1;
        if ((fr_q_r & sprite_bits) != 64'h0) vf_nxt = 1'b1;
        cnt_nxt   = cnt_r + 4'd1;
        state_nxt = ST_DR0;
      end
      // Decimal digits by repeated subtraction
      ST_BH: begin
        if (alu_sum[8]) begin
          aux_nxt  = alu_sum[7:0];
          hund_nxt = hund_r + 2'd1;
        end else begin
          state_nxt = ST_BT;
        end
      end
      ST_BT: begin
        if (alu_sum[8]) begin
          aux_nxt  = alu_sum[7:0];
          tens_nxt = tens_r + 4'd1;
        end else begin
          state_nxt = ST_BW0;
        end
      end
      ST_BW0: begin
        mem_we    = 1'b1;
        mem_wdata = {6'h0, hund_r};
        state_nxt = ST_BW1;
      end
      ST_BW1: begin
        mem_we    = 1'b1;
        mem_wdata = {4'h0, tens_r};
        state_nxt = ST_BW2;
      end
      ST_BW2: begin
        mem_we    = 1'b1;
        mem_wdata = aux_r;
        state_nxt = ST_DONE;
      end
      // Register block store
      ST_ST0: begin
        rf_raddr  = cnt_r;
        state_nxt = ST_ST1;
      end
      ST_ST1: begin
        mem_we    = 1'b1;
        mem_wdata = rf_q_r;
        cnt_nxt   = cnt_r + 4'd1;
        state_nxt = (cnt_r == op_x) ? ST_DONE : ST_ST0;
      end
      // Register block load
      ST_LD0: state_nxt = ST_LD1;
      ST_LD1: begin
        rf_we     = 1'b1;
        rf_waddr  = cnt_r;
        rf_wdata  = mem_q_r;
        cnt_nxt   = cnt_r + 4'd1;
        state_nxt = (cnt_r == op_x) ? ST_DONE : ST_LD0;
      end
      // Hand the result to the output register
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt          = res_r;
          out_nxt.pc_now   = pc_r;
          out_nxt.sound_on = (sound_r != 8'h0);
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (rf_we) rf_vld_nxt[rf_waddr] = 1'b1;
    if (fr_we) fr_vld_nxt[draw_row[4:0]] = 1'b1;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_cnt_r  <= 7'h0;
      pc_r        <= chip8_pkg::PC_RESET;
      i_r         <= 16'h0;
      sp_r        <= '0;
      delay_r     <= 8'h0;
      sound_r     <= 8'h0;
      keys_r      <= 16'h0;
      rf_vld_r    <= 16'h0;
      fr_vld_r    <= 32'h0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      pc_r        <= pc_nxt;
      i_r         <= i_nxt;
      sp_r        <= sp_nxt;
      delay_r     <= delay_nxt;
      sound_r     <= sound_nxt;
      keys_r      <= keys_nxt;
      rf_vld_r    <= rf_vld_nxt;
      fr_vld_r    <= fr_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    op_r   <= op_nxt;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    cnt_r  <= cnt_nxt;
    aux_r  <= aux_nxt;
    hund_r <= hund_nxt;
    tens_r <= tens_nxt;
    vf_r   <= vf_nxt;
  end

  // Main memory
  always_ff @(posedge clk) begin
    if (mem_we) main_mem_r[mem_waddr] <= mem_wdata;
    mem_q_r <= main_mem_r[mem_raddr];
  end

  // Register file, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem_r[rf_waddr] <= rf_wdata;
    rf_q_r <= rf_vld_r[rf_raddr] ? rf_mem_r[rf_raddr] : 8'h0;
  end

  // Frame buffer, cleared rows read as zero
  always_ff @(posedge clk) begin
    if (fr_we) frame_mem_r[draw_row[4:0]] <= fr_wdata;
    fr_q_r <= fr_vld_r[fr_raddr] ? frame_mem_r[fr_raddr] : 64'h0;
  end

  // Return stack
  always_ff @(posedge clk) begin
    if (stk_we) stack_r[sp_r[IDX_W-1:0]] <= pc_r;
  end

  // Checks
  `C8_ASSERT_NOW(a_sp_bound, 1'b1, sp_r <= SP_W'(STACK_DEPTH), "stack pointer past depth")
  `C8_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
  `C8_ASSERT_NOW(a_draw_rows, state_r == ST_DR1, cnt_r < op_n, "sprite row past height")
  `C8_ASSERT_NOW(a_status_exec, out_valid_r && out_r.status != chip8_pkg::STAT_OK,
                 out_r.opcode_done != 16'h0, "stack status on non-instruction")

endmodule

### tb/chip8_processor_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// CHIP-8 processor core testbench
// Drives memory, key, timer, execute and display-row requests through the
// request channel and checks every result against a behavioral machine model
// kept in this file. Directed tests cover flags, flow, stack limits, drawing,
// keys, timers and block moves; a random phase writes each instruction at the
// current PC before executing it.
// ---------------------------------------------------------------------------
module chip8_processor_core_test;

  localparam int unsigned STACK_SLOTS = chip8_pkg::STACK_DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned RAND_ITEMS  = 1950;

  // Request functions with no effect
  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  chip8_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  chip8_pkg::out_item_t out_data;

  // machine model state
  logic [7:0]  mem_q [chip8_pkg::MEM_BYTES];
  bit          written [chip8_pkg::MEM_BYTES];
  logic [7:0]  vreg [16];
  logic [15:0] ireg;
  logic [11:0] pc;
  logic [11:0] ret_stack [STACK_SLOTS];
  int unsigned sp;
  logic [63:0] frame [32];
  logic [7:0]  delay_t;
  logic [7:0]  sound_t;
  logic [15:0] keys;

  chip8_pkg::out_item_t result_q [$];
  int          errors;
  int          items_sent;
  int unsigned idle_cycles;
  bit          no_idle;

  chip8_processor_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the machine model by one request and return its result
  function automatic chip8_pkg::out_item_t machine_step(chip8_pkg::in_item_t r);
    chip8_pkg::out_item_t o;
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn, nxt, skp;
    logic [63:0] bits;
    logic [8:0]  sum;
    int          xc, yc;
    bit          found;
    o = '0;
    case (r.func)
      chip8_pkg::FUNC_MEM_WR: begin
        mem_q[r.addr] = r.data;
        written[r.addr] = 1'b1;
      end
      chip8_pkg::FUNC_MEM_RD: o.read_byte = mem_q[r.addr];
      chip8_pkg::FUNC_SET_KEY: keys[r.key_index] = r.key_down;
      chip8_pkg::FUNC_TICK: begin
        if (delay_t != 0) delay_t--;
        if (sound_t != 0) sound_t--;
      end
      chip8_pkg::FUNC_ROW_RD: if (r.addr < 32) o.row_pixels = frame[r.addr];
      chip8_pkg::FUNC_EXEC: begin
        op = {mem_q[pc], mem_q[pc + 12'd1]};
        x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
        vx = vreg[x]; vy = vreg[y];
        nxt = pc + 12'd2; skp = pc + 12'd4;
        pc = nxt;
        o.opcode_done = op;
        case (op[15:12])
          chip8_pkg::OPH_SYS: begin
            if (op == chip8_pkg::OP_CLS) begin
              for (int i = 0; i < 32; i++) frame[i] = '0;
              o.display_changed = 1'b1;
            end else if (op == chip8_pkg::OP_RET) begin
              if (sp == 0) o.status = chip8_pkg::STAT_UNDERFLOW;
              else begin
                sp--;
                pc = ret_stack[sp];
              end
            end
          end
          chip8_pkg::OPH_JP: pc = nnn;
          chip8_pkg::OPH_CALL: begin
            if (sp >= STACK_SLOTS) o.status = chip8_pkg::STAT_OVERFLOW;
            else begin
              ret_stack[sp] = nxt;
              sp++;
              pc = nnn;
            end
          end
          chip8_pkg::OPH_SE_NN:  if (vx == nn) pc = skp;
          chip8_pkg::OPH_SNE_NN: if (vx != nn) pc = skp;
          chip8_pkg::OPH_SE_XY:  if (vx == vy) pc = skp;
          chip8_pkg::OPH_LD_NN:  vreg[x] = nn;
          chip8_pkg::OPH_ADD_NN: vreg[x] = vx + nn;
          chip8_pkg::OPH_ALU: begin
            case (n)
              chip8_pkg::ALU_MOV: vreg[x] = vy;
              chip8_pkg::ALU_OR:  vreg[x] = vx | vy;
              chip8_pkg::ALU_AND: vreg[x] = vx & vy;
              chip8_pkg::ALU_XOR: vreg[x] = vx ^ vy;
              chip8_pkg::ALU_ADD: begin
                sum = {1'b0, vx} + {1'b0, vy};
                vreg[x] = sum[7:0];
                vreg[15] = {7'd0, sum[8]};
              end
              chip8_pkg::ALU_SUB: begin
                vreg[x] = vx - vy;
                vreg[15] = {7'd0, vx >= vy};
              end
              chip8_pkg::ALU_SUBN: begin
                vreg[x] = vy - vx;
                vreg[15] = {7'd0, vy >= vx};
              end
              chip8_pkg::ALU_SHR: begin
                vreg[x] = vx >> 1;
                vreg[15] = {7'd0, vx[0]};
              end
              chip8_pkg::ALU_SHL: begin
                vreg[x] = vx << 1;
                vreg[15] = {7'd0, vx[7]};
              end
              default: ;
            endcase
          end
          chip8_pkg::OPH_SNE_XY: if (vx != vy) pc = skp;
          chip8_pkg::OPH_LD_I:   ireg = {4'd0, nnn};
          chip8_pkg::OPH_JP_V0:  pc = nnn + {4'd0, vx};
          chip8_pkg::OPH_RND:    vreg[x] = r.rand_byte & nn;
          chip8_pkg::OPH_DRW: begin
            xc = vx % 64;
            yc = vy % 32;
            vreg[15] = 8'd0;
            for (int i = 0; i < n && yc + i < 32; i++) begin
              bits = {mem_q[ireg[11:0] + 12'(i)], 56'd0} >> xc;
              if ((frame[yc + i] & bits) != 0) vreg[15] = 8'd1;
              frame[yc + i] ^= bits;
            end
            o.display_changed = 1'b1;
          end
          chip8_pkg::OPH_KEY: begin
            if (nn == chip8_pkg::NN_SKP && keys[vx[3:0]]) pc = skp;
            else if (nn == chip8_pkg::NN_SKNP && !keys[vx[3:0]]) pc = skp;
          end
          default: begin
            case (nn)
              chip8_pkg::NN_GET_DT: vreg[x] = delay_t;
              chip8_pkg::NN_SET_DT: delay_t = vx;
              chip8_pkg::NN_SET_ST: sound_t = vx;
              chip8_pkg::NN_ADD_I:  ireg = ireg + {8'd0, vx};
              chip8_pkg::NN_WAIT_KEY: begin
                found = 1'b0;
                for (int i = 0; i < 16; i++) begin
                  if (!found && keys[i]) begin
                    vreg[x] = 8'(i);
                    found = 1'b1;
                  end
                end
                if (!found) begin
                  pc = nxt - 12'd2;
                  o.waiting_key = 1'b1;
                end
              end
              chip8_pkg::NN_FONT: ireg = 16'(5 * vx);
              chip8_pkg::NN_BCD: begin
                mem_q[ireg[11:0]] = vx / 100;
                mem_q[ireg[11:0] + 12'd1] = (vx / 10) % 10;
                mem_q[ireg[11:0] + 12'd2] = vx % 10;
                for (int i = 0; i < 3; i++) written[ireg[11:0] + 12'(i)] = 1'b1;
              end
              chip8_pkg::NN_STORE: begin
                for (int i = 0; i <= x; i++) begin
                  mem_q[ireg[11:0] + 12'(i)] = vreg[i];
                  written[ireg[11:0] + 12'(i)] = 1'b1;
                end
              end
              chip8_pkg::NN_LOAD:
                for (int i = 0; i <= x; i++) vreg[i] = mem_q[ireg[11:0] + 12'(i)];
              default: ;
            endcase
          end
        endcase
      end
      default: ;
    endcase
    o.pc_now = pc;
    o.sound_on = (sound_t != 0);
    return o;
  endfunction

  function automatic chip8_pkg::in_item_t random_fields();
    chip8_pkg::in_item_t r;
    r.func = 3'($urandom);
    r.addr = 12'($urandom);
    r.data = 8'($urandom);
    r.key_index = 4'($urandom);
    r.key_down = 1'($urandom);
    r.rand_byte = 8'($urandom);
    return r;
  endfunction

  // Drive one request, hold it until accepted, then record its expectation
  task automatic send(chip8_pkg::in_item_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    result_q.push_back(machine_step(r));
    items_sent++;
  endtask

  task automatic put_byte(logic [11:0] a, logic [7:0] d);
    chip8_pkg::in_item_t r;
    r = random_fields();
    r.func = chip8_pkg::FUNC_MEM_WR;
    r.addr = a;
    r.data = d;
    send(r);
  endtask

  task automatic request(logic [2:0] f, logic [11:0] a);
    chip8_pkg::in_item_t r;
    r = random_fields();
    r.func = f;
    r.addr = a;
    send(r);
  endtask

  task automatic set_key(logic [3:0] k, logic down);
    chip8_pkg::in_item_t r;
    r = random_fields();
    r.func = chip8_pkg::FUNC_SET_KEY;
    r.key_index = k;
    r.key_down = down;
    send(r);
  endtask

  // Fill any unwritten bytes an instruction reads, place it at PC, execute
  task automatic run_op(logic [15:0] op);
    int span;
    logic [11:0] a;
    span = 0;
    if (op[15:12] == chip8_pkg::OPH_DRW) span = op[3:0];
    else if (op[15:12] == chip8_pkg::OPH_MISC && op[7:0] == chip8_pkg::NN_LOAD)
      span = op[11:8] + 1;
    for (int i = 0; i < span; i++) begin
      a = ireg[11:0] + 12'(i);
      if (!written[a]) put_byte(a, 8'($urandom));
    end
    put_byte(pc, op[15:8]);
    put_byte(pc + 12'd1, op[7:0]);
    request(chip8_pkg::FUNC_EXEC, 12'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (result_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_memory();
    request(chip8_pkg::FUNC_MEM_RD, 12'd0);
    request(chip8_pkg::FUNC_MEM_RD, 12'd79);
    put_byte(12'hFFF, 8'hFF);
    request(chip8_pkg::FUNC_MEM_RD, 12'hFFF);
    put_byte(12'h100, 8'h00);
    request(chip8_pkg::FUNC_MEM_RD, 12'h100);
    request(FUNC_SPARE_LO, 12'hABC);
    request(FUNC_SPARE_HI, 12'h123);
  endtask

  task automatic test_arith_flags();
    run_op(16'h60FF);
    run_op(16'h6101);
    run_op(16'h8014);   // carry out
    run_op(16'h8015);   // borrow
    run_op(16'h8107);
    run_op(16'h6F81);
    run_op(16'h8FFE);   // flag overwrites the shifted VF
    run_op(16'h6F03);
    run_op(16'h8FF6);
    run_op(16'h5F00);
    run_op(16'h9F00);
  endtask

  task automatic test_flow();
    run_op(16'h1FFE);
    run_op(16'h3000);   // no skip; PC wraps past the top of memory
    run_op(16'h60FF);
    run_op(16'hBFFF);   // jump plus V0 wraps
    run_op(16'h4000);
    run_op(16'h0123);   // undefined only advances
  endtask

  task automatic test_stack();
    for (int i = 0; i <= STACK_SLOTS; i++)
      run_op({chip8_pkg::OPH_CALL, 12'h300 + 12'(i * 8)});
    for (int i = 0; i <= STACK_SLOTS; i++) run_op(chip8_pkg::OP_RET);
  endtask

  task automatic test_display();
    run_op(16'h603C);
    run_op(16'h611E);
    run_op(16'hA000);
    run_op(16'hD01F);   // clipped on right and bottom edges
    run_op(16'hD015);   // collision
    request(chip8_pkg::FUNC_ROW_RD, 12'd30);
    request(chip8_pkg::FUNC_ROW_RD, 12'd31);
    request(chip8_pkg::FUNC_ROW_RD, 12'd32);
    request(chip8_pkg::FUNC_ROW_RD, 12'hFFF);
    run_op(16'h6200);
    run_op(16'hA04B);
    run_op(16'hD225);
    request(chip8_pkg::FUNC_ROW_RD, 12'd0);
    run_op(chip8_pkg::OP_CLS);
    request(chip8_pkg::FUNC_ROW_RD, 12'd31);
  endtask

  task automatic test_keys_timers();
    for (int k = 0; k < 16; k++) set_key(4'(k), 1'b0);
    run_op(16'hF30A);   // no key held: stays put
    set_key(4'd15, 1'b1);
    set_key(4'd5, 1'b1);
    run_op(16'hF30A);
    run_op(16'hE39E);
    run_op(16'hE3A1);
    set_key(4'd5, 1'b0);
    run_op(16'hE39E);
    run_op(16'hE3A1);
    run_op(16'h6003);
    run_op(16'hF015);
    run_op(16'hF018);
    for (int i = 0; i < 4; i++) request(chip8_pkg::FUNC_TICK, 12'd0);
    run_op(16'hF407);
  endtask

  task automatic test_block_moves();
    run_op(16'h60FF);
    run_op(16'hA300);
    run_op(16'hF033);
    run_op(16'hF265);
    run_op(16'hAFFC);
    run_op(16'hFF55);   // addresses wrap past the top
    run_op(16'hFF65);
    run_op(16'hF01E);
    run_op(16'hF529);
  endtask

  // Random instruction with valid encodings favored
  function automatic logic [15:0] random_op();
    logic [15:0] op;
    logic [7:0]  nn_pick [11];
    logic [3:0]  alu_pick [9];
    nn_pick = '{chip8_pkg::NN_GET_DT, chip8_pkg::NN_WAIT_KEY, chip8_pkg::NN_SET_DT,
                chip8_pkg::NN_SET_ST, chip8_pkg::NN_ADD_I, chip8_pkg::NN_FONT,
                chip8_pkg::NN_BCD, chip8_pkg::NN_STORE, chip8_pkg::NN_LOAD,
                chip8_pkg::NN_SKP, chip8_pkg::NN_SKNP};
    alu_pick = '{chip8_pkg::ALU_MOV, chip8_pkg::ALU_OR, chip8_pkg::ALU_AND,
                 chip8_pkg::ALU_XOR, chip8_pkg::ALU_ADD, chip8_pkg::ALU_SUB,
                 chip8_pkg::ALU_SHR, chip8_pkg::ALU_SUBN, chip8_pkg::ALU_SHL};
    op = 16'($urandom);
    case (op[15:12])
      chip8_pkg::OPH_SYS: begin
        case ($urandom_range(0, 4))
          0: op = chip8_pkg::OP_CLS;
          1, 2: op = chip8_pkg::OP_RET;
          default: ;
        endcase
      end
      chip8_pkg::OPH_ALU:
        if ($urandom_range(0, 7) != 0) op[3:0] = alu_pick[$urandom_range(0, 8)];
      chip8_pkg::OPH_KEY:
        if ($urandom_range(0, 5) != 0) op[7:0] = nn_pick[$urandom_range(9, 10)];
      chip8_pkg::OPH_MISC:
        if ($urandom_range(0, 7) != 0) op[7:0] = nn_pick[$urandom_range(0, 8)];
      default: ;
    endcase
    return op;
  endfunction

  task automatic test_random();
    int          pick;
    logic [11:0] a;
    bit          paused;
    paused = 1'b0;
    while (items_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 99) == 0) no_idle = !no_idle;
      if (!paused && items_sent > RAND_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 19);
      case (pick)
        0: begin
          a = 12'($urandom);
          if (!written[a]) put_byte(a, 8'($urandom));
          request(chip8_pkg::FUNC_MEM_RD, a);
        end
        1: set_key(4'($urandom), 1'($urandom));
        2: request(chip8_pkg::FUNC_TICK, 12'($urandom));
        3: request(chip8_pkg::FUNC_ROW_RD,
                   $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 31)));
        4: put_byte(12'($urandom), 8'($urandom));
        5: request($urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO, 12'($urandom));
        default: run_op(random_op());
      endcase
    end
    no_idle = 1'b0;
  endtask

  // Compare one result field, report a mismatch
  task automatic compare(string field, logic [63:0] expv, logic [63:0] gotv);
    if (expv !== gotv) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $realtime, field, expv, gotv);
    end
  endtask

  // Accept results with random stalls and check them in order
  initial begin
    int                   stall;
    chip8_pkg::out_item_t want;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $realtime, out_data);
      end else begin
        want = result_q.pop_front();
        compare("pc_now", 64'(want.pc_now), 64'(out_data.pc_now));
        compare("opcode_done", 64'(want.opcode_done), 64'(out_data.opcode_done));
        compare("read_byte", 64'(want.read_byte), 64'(out_data.read_byte));
        compare("row_pixels", want.row_pixels, out_data.row_pixels);
        compare("display_changed", 64'(want.display_changed),
                64'(out_data.display_changed));
        compare("waiting_key", 64'(want.waiting_key), 64'(out_data.waiting_key));
        compare("sound_on", 64'(want.sound_on), 64'(out_data.sound_on));
        compare("status", 64'(want.status), 64'(out_data.status));
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    errors = 0;
    items_sent = 0;
    no_idle = 1'b0;
    for (int i = 0; i < chip8_pkg::MEM_BYTES; i++) begin
      mem_q[i] = (i < chip8_pkg::FONT_BYTES) ? chip8_pkg::FONT[i] : 8'd0;
      written[i] = (i < chip8_pkg::FONT_BYTES);
    end
    for (int i = 0; i < 16; i++) vreg[i] = 8'd0;
    for (int i = 0; i < 32; i++) frame[i] = '0;
    ireg = '0;
    pc = chip8_pkg::PC_RESET;
    sp = 0;
    delay_t = '0;
    sound_t = '0;
    keys = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_memory();
    test_arith_flags();
    test_flow();
    test_stack();
    test_display();
    test_keys_timers();
    test_block_moves();
    test_random();
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/chip8_pkg.sv
design/chip8_processor_core.sv
tb/chip8_processor_core_test.sv
